// File: hdl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants for the keyword token scanner
// Result record, per-request scan output and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned RES_DEPTH         = 4;   // power of two, at least 2

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  char_code;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [15:0] length;
    logic        last;
  } res_t;

  // Up to two results per accepted request, in order r0 then r1.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } scan_out_t;

endpackage

`default_nettype wire

// File: hdl/keyword_token_scanner.sv
// ----------------------------------------------------------------------------
// keyword_token_scanner: streaming lexer, one source byte per request
// Results are registered in the result queue and leave its head one at a time.
// Throughput: one request per cycle unless the result queue stalls the input.
// Reset clears lexer state, positions and the four-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_token_scanner #(
  parameter int unsigned POSITION_BITS = kts_pkg::POSITION_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        end_of_input_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       kind_o,
  output logic [7:0]       char_code_o,
  output logic [15:0]      start_line_o,
  output logic [15:0]      start_col_o,
  output logic [15:0]      length_o,
  output logic             last_o
);

  // Request handshake on the input side.
  logic               in_acc;
  kts_pkg::scan_out_t scan;
  kts_pkg::res_t      head;

  assign in_acc = in_valid_i && !in_stall_o;

  // Classify the byte against the current lexer state in one pass; the
  // state registers advance at the same edge the request is taken.
  kts_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_acc_i       (in_acc),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .scan_o         (scan)
  );

  // Queue the finished tokens; the queue stalls the input whenever it
  // cannot absorb a worst-case pair of results.
  kts_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (scan),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (head),
    .in_stall_o  (in_stall_o)
  );

  assign kind_o       = head.kind;
  assign char_code_o  = head.char_code;
  assign start_line_o = head.start_line;
  assign start_col_o  = head.start_col;
  assign length_o     = head.length;
  assign last_o       = head.last;

`ifndef SYNTHESIS
  // Results only come from an accepted request.
  a_res_needs_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan.count != 2'd0) |-> in_acc)
    else $error("scanner produced results without a request");

  // In a result pair only the second one closes the request.
  a_pair_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan.count == 2'd2) |-> (!scan.r0.last && scan.r1.last))
    else $error("wrong last flags on a result pair");

  // Output valid drops only after the head was taken.
  a_valid_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_valid_o && !out_stall_i))
    else $error("result withdrawn without being taken");
`endif

endmodule

`default_nettype wire

// File: hdl/kts_scan.sv
// ----------------------------------------------------------------------------
// kts_scan: lexer state and single-pass classification
// Updates mode, keyword mask and positions; emits up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_scan #(
  parameter int unsigned POSITION_BITS = kts_pkg::POSITION_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_acc_i,
  input  wire logic [7:0]          ch_i,
  input  wire logic                end_of_input_i,
  output kts_pkg::scan_out_t       scan_o
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_IDENT   = 2'd1;
  localparam logic [1:0] MODE_NUMBER  = 2'd2;
  localparam logic [1:0] MODE_COMMENT = 2'd3;

  localparam logic [3:0] KIND_EOF     = 4'd0;
  localparam logic [3:0] KIND_IDENT   = 4'd1;
  localparam logic [3:0] KIND_NUMBER  = 4'd2;
  localparam logic [3:0] KIND_CHAR    = 4'd3;
  localparam logic [3:0] KIND_KEY0    = 4'd4;

  localparam int unsigned KEY_COUNT   = 10;
  localparam logic [KEY_COUNT-1:0] MASK_ALL = '1;
  localparam logic [15:0] LEN_MAX     = 16'hFFFF;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef logic [POSITION_BITS-1:0] pos_t;

  function automatic logic [63:0] key_text(input logic [3:0] k);
    logic [63:0] t;
    unique case (k)
      4'd0:    t = "function";
      4'd1:    t = {"return", 16'h0};
      4'd2:    t = {"extern", 16'h0};
      4'd3:    t = {"if", 48'h0};
      4'd4:    t = {"else", 32'h0};
      4'd5:    t = {"for", 40'h0};
      4'd6:    t = {"in", 48'h0};
      4'd7:    t = {"binary", 16'h0};
      4'd8:    t = {"unary", 24'h0};
      4'd9:    t = {"var", 40'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] key_len(input logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      4'd0:    l = 4'd8;
      4'd1:    l = 4'd6;
      4'd2:    l = 4'd6;
      4'd3:    l = 4'd2;
      4'd4:    l = 4'd4;
      4'd5:    l = 4'd3;
      4'd6:    l = 4'd2;
      4'd7:    l = 4'd6;
      4'd8:    l = 4'd5;
      4'd9:    l = 4'd3;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] k, input logic [2:0] i);
    logic [63:0] t;
    t = key_text(k);
    return t[63 - 8 * i -: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  logic [1:0]           mode_q, mode_d;
  logic [KEY_COUNT-1:0] mask_q, mask_d;
  logic [15:0]          len_q, len_d;
  pos_t                 line_q, line_d;
  pos_t                 col_q, col_d;
  pos_t                 tok_line_q, tok_line_d;
  pos_t                 tok_col_q, tok_col_d;
  logic                 done_q, done_d;

  logic                 is_nl;
  logic                 ident_first;
  logic                 ident_rest;
  logic                 num_char;
  pos_t                 line_nx;
  pos_t                 col_nx;
  pos_t                 col_inc;
  logic [15:0]          len_inc;
  logic [KEY_COUNT-1:0] keep_mask;
  logic [KEY_COUNT-1:0] first_mask;
  logic [3:0]           ident_kind;
  logic                 ident_hit;
  kts_pkg::res_t        tok_res;
  kts_pkg::res_t        eof_res;
  kts_pkg::res_t        chr_res;
  kts_pkg::scan_out_t   out;
  logic                 go_idle;

  assign is_nl       = (ch_i == CH_LF) || (ch_i == CH_CR);
  assign ident_first = is_alpha(ch_i) || (ch_i == CH_UNDER);
  assign ident_rest  = ident_first || is_digit(ch_i);
  assign num_char    = is_digit(ch_i) || (ch_i == CH_DOT);
  assign col_inc     = col_q + pos_t'(1);
  assign line_nx     = is_nl ? line_q + pos_t'(1) : line_q;
  assign col_nx      = is_nl ? '0 : col_inc;
  assign len_inc     = (len_q == LEN_MAX) ? len_q : len_q + 16'd1;

  // Narrow the keyword mask by the character at the current token offset.
  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      keep_mask[k]  = mask_q[k] && (len_q < 16'(key_len(4'(k)))) &&
                      (key_char(4'(k), len_q[2:0]) == ch_i);
      first_mask[k] = (key_char(4'(k), 3'd0) == ch_i);
    end
  end

  // First surviving keyword whose length equals the token length.
  always_comb begin
    ident_kind = KIND_IDENT;
    ident_hit  = 1'b0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (!ident_hit && mask_q[k] && (len_q == 16'(key_len(4'(k))))) begin
        ident_kind = KIND_KEY0 + 4'(k);
        ident_hit  = 1'b1;
      end
    end
  end

  always_comb begin
    tok_res            = '0;
    tok_res.kind       = (mode_q == MODE_IDENT) ? ident_kind : KIND_NUMBER;
    tok_res.start_line = 16'(tok_line_q);
    tok_res.start_col  = 16'(tok_col_q);
    tok_res.length     = len_q;

    eof_res            = '0;
    eof_res.kind       = KIND_EOF;
    eof_res.start_line = (mode_q == MODE_COMMENT) ? 16'(tok_line_q) : 16'(line_q);
    eof_res.start_col  = (mode_q == MODE_COMMENT) ? 16'(tok_col_q) : 16'(col_inc);

    chr_res            = '0;
    chr_res.kind       = KIND_CHAR;
    chr_res.char_code  = ch_i;
    chr_res.start_line = 16'(line_nx);
    chr_res.start_col  = 16'(col_nx);
    chr_res.length     = 16'd1;
  end

  always_comb begin
    mode_d     = mode_q;
    mask_d     = mask_q;
    len_d      = len_q;
    line_d     = line_q;
    col_d      = col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    done_d     = done_q;
    out        = '0;
    go_idle    = 1'b0;

    if (in_acc_i && !done_q) begin
      if (end_of_input_i) begin
        if ((mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER)) begin
          out.r0    = tok_res;
          out.r1    = eof_res;
          out.count = 2'd2;
        end else begin
          out.r0    = eof_res;
          out.count = 2'd1;
        end
        col_d  = col_inc;
        mode_d = MODE_IDLE;
        done_d = 1'b1;
      end else begin
        line_d = line_nx;
        col_d  = col_nx;
        unique case (mode_q)
          MODE_IDENT: begin
            if (ident_rest) begin
              mask_d = keep_mask;
              len_d  = len_inc;
            end else begin
              out.r0    = tok_res;
              out.count = 2'd1;
              go_idle   = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (num_char) begin
              len_d = len_inc;
            end else begin
              out.r0    = tok_res;
              out.count = 2'd1;
              go_idle   = 1'b1;
            end
          end
          MODE_COMMENT: begin
            if (is_nl) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_IDLE: begin
            go_idle = 1'b1;
          end
        endcase

        if (go_idle) begin
          mode_d = MODE_IDLE;
          if (is_space(ch_i)) begin
            // skip
          end else if (ident_first) begin
            mode_d     = MODE_IDENT;
            tok_line_d = line_nx;
            tok_col_d  = col_nx;
            len_d      = 16'd1;
            mask_d     = first_mask;
          end else if (num_char) begin
            mode_d     = MODE_NUMBER;
            tok_line_d = line_nx;
            tok_col_d  = col_nx;
            len_d      = 16'd1;
            mask_d     = MASK_ALL;
          end else if (ch_i == CH_HASH) begin
            mode_d     = MODE_COMMENT;
            tok_line_d = line_nx;
            tok_col_d  = col_nx;
            len_d      = 16'd0;
            mask_d     = MASK_ALL;
          end else if (out.count == 2'd0) begin
            out.r0    = chr_res;
            out.count = 2'd1;
          end else begin
            out.r1    = chr_res;
            out.count = 2'd2;
          end
        end
      end

      // Flag the final result of this request.
      if (out.count == 2'd2) begin
        out.r1.last = 1'b1;
      end else if (out.count == 2'd1) begin
        out.r0.last = 1'b1;
      end
    end
  end

  assign scan_o = out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      mask_q     <= MASK_ALL;
      len_q      <= '0;
      line_q     <= '0;
      col_q      <= '0;
      tok_line_q <= '0;
      tok_col_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      mask_q     <= mask_d;
      len_q      <= len_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      done_q     <= done_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kts_res_fifo.sv
// ----------------------------------------------------------------------------
// kts_res_fifo: result queue between the scanner and the output channel
// Takes up to two results per cycle, hands out one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_res_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kts_pkg::scan_out_t  push_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output kts_pkg::res_t            out_res_o,
  output logic                     in_stall_o
);

  localparam int unsigned DEPTH = kts_pkg::RES_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  kts_pkg::res_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  // Hold off new requests unless two slots are free.
  assign in_stall_o  = (cnt_q > CNT_W'(DEPTH - 2));
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire
